// ===== rtl/tllru_pkg.sv =====
// Shared types, sizes and codes for the two-list LRU page cache.
// Used by tllru_ctrl, tllru_dpath and the top level; depends on nothing.
`default_nettype none

package tllru_pkg;

   localparam int SLOTS   = 256;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int TOT_W   = CNT_W + 1;
   localparam int PAGE_W  = 52;
   localparam int LIMIT_W = 8;
   localparam int KIND_W  = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_MISS     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INACTIVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ACTIVE   = 2'd2;

   // List selectors.
   localparam logic LIST_ACTIVE   = 1'b0;
   localparam logic LIST_INACTIVE = 1'b1;

   // Where the working slot register is loaded from.
   typedef enum logic [1:0] {
      CUR_HIT,
      CUR_ATAIL,
      CUR_VICTIM,
      CUR_FREE
   } cur_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        latch_req;
      logic        match;
      logic        encode;
      logic        load_cur;
      cur_src_type cur_src;
      logic        read;
      logic        remove;
      logic        push;
      logic        lst;
      logic        or_wr;
      logic        capture_ev;
      logic        insert;
      logic        load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit_found;
      logic hit_active;
      logic evict_needed;
      logic victim_lst;
      logic demote_needed;
   } stat_type;

   // Index of the set bit of a one-hot (or all-zero) vector.
   function automatic logic [SLOT_W-1:0] enc_onehot(input logic [SLOTS-1:0] v);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (v[i]) begin
            r = r | SLOT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tllru_dpath.sv =====
// Datapath of the two-list LRU page cache: tag match, list memories, ends and counts.
// Depends on tllru_pkg; driven by commands from tllru_ctrl.
`default_nettype none

module tllru_dpath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  tllru_pkg::cmd_type         cmd,
   output tllru_pkg::stat_type              stat,
   input  wire  [tllru_pkg::PAGE_W-1:0]     req_page_number,
   input  wire                              req_is_write,
   input  wire                              csr_valid,
   input  wire  [tllru_pkg::LIMIT_W-1:0]    csr_data,
   output logic [tllru_pkg::KIND_W-1:0]     rsp_hit_kind,
   output logic                             rsp_evicted,
   output logic [tllru_pkg::PAGE_W-1:0]     rsp_evicted_page,
   output logic                             rsp_evicted_dirty
);

   localparam int SLOTS  = tllru_pkg::SLOTS;
   localparam int SLOT_W = tllru_pkg::SLOT_W;
   localparam int CNT_W  = tllru_pkg::CNT_W;
   localparam int TOT_W  = tllru_pkg::TOT_W;
   localparam int PAGE_W = tllru_pkg::PAGE_W;

   // Request and configuration registers.
   logic [PAGE_W-1:0]              page_ff;
   logic                           wr_ff;
   logic [tllru_pkg::LIMIT_W-1:0]  limit_ff;

   // Per-slot state held in flip-flops.
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   active_ff;
   logic [PAGE_W-1:0]  tag_cam_ff [SLOTS];

   // Lookup results.
   logic [SLOTS-1:0]   match_ff;
   logic [SLOTS-1:0]   free_oh_ff;
   logic [SLOT_W-1:0]  hit_slot_ff;
   logic [SLOT_W-1:0]  free_slot_ff;
   logic               hit_found_ff;
   logic               hit_active_ff;

   // Working slot and its dirty mark.
   logic [SLOT_W-1:0]  cur_ff;
   logic [SLOT_W-1:0]  cur_in;
   logic               cur_dirty_ff;
   logic               hit_dirty_ff;
   logic               take_dirty;

   // List ends and counts.
   logic [SLOT_W-1:0]  head_ff  [2];
   logic [SLOT_W-1:0]  tail_ff  [2];
   logic [CNT_W-1:0]   count_ff [2];
   logic [TOT_W-1:0]   total;

   // Memories and their registered read data.
   logic [PAGE_W-1:0]  tag_mem   [SLOTS];
   logic               dirty_mem [SLOTS];
   logic [SLOT_W-1:0]  newer_mem [SLOTS];
   logic [SLOT_W-1:0]  older_mem [SLOTS];
   logic [PAGE_W-1:0]  rd_tag_ff;
   logic               rd_dirty_ff;
   logic [SLOT_W-1:0]  rd_newer_ff;
   logic [SLOT_W-1:0]  rd_older_ff;

   // Eviction capture.
   logic               ev_ff;
   logic [PAGE_W-1:0]  ev_page_ff;
   logic               ev_dirty_ff;

   // Link and dirty write ports.
   logic               is_head;
   logic               is_tail;
   logic               list_empty;
   logic               newer_we;
   logic [SLOT_W-1:0]  newer_wa;
   logic [SLOT_W-1:0]  newer_wd;
   logic               older_we;
   logic [SLOT_W-1:0]  older_wa;
   logic [SLOT_W-1:0]  older_wd;
   logic               push_dirty;
   logic [SLOTS-1:0]   match_in;
   logic [SLOTS-1:0]   free_vec;

   // Request latch and page limit register.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         page_ff <= req_page_number;
         wr_ff   <= req_is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= tllru_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // Parallel tag compare and lowest free slot, registered.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = valid_ff[i] && (tag_cam_ff[i] == page_ff);
      end
      free_vec = ~valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
      end else if (cmd.match) begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         free_oh_ff <= free_vec & (~free_vec + SLOTS'(1));
      end
      if (cmd.encode) begin
         hit_slot_ff   <= tllru_pkg::enc_onehot(match_ff);
         free_slot_ff  <= tllru_pkg::enc_onehot(free_oh_ff);
         hit_found_ff  <= |match_ff;
         hit_active_ff <= |(match_ff & active_ff);
      end
   end

   // Status toward the controller.
   assign total = TOT_W'(count_ff[0]) + TOT_W'(count_ff[1]);

   always_comb begin
      stat.hit_found     = hit_found_ff;
      stat.hit_active    = hit_active_ff;
      stat.evict_needed  = (total != '0) &&
                           ((total > TOT_W'(limit_ff)) || (total >= TOT_W'(SLOTS)));
      stat.victim_lst    = (count_ff[tllru_pkg::LIST_INACTIVE] != '0) ?
                           tllru_pkg::LIST_INACTIVE : tllru_pkg::LIST_ACTIVE;
      stat.demote_needed = count_ff[tllru_pkg::LIST_ACTIVE] >
                           count_ff[tllru_pkg::LIST_INACTIVE];
   end

   // Working slot selection.
   always_comb begin
      case (cmd.cur_src)
         tllru_pkg::CUR_HIT:    cur_in = hit_slot_ff;
         tllru_pkg::CUR_ATAIL:  cur_in = tail_ff[tllru_pkg::LIST_ACTIVE];
         tllru_pkg::CUR_VICTIM: cur_in = tail_ff[stat.victim_lst];
         tllru_pkg::CUR_FREE:   cur_in = free_slot_ff;
         default:               cur_in = hit_slot_ff;
      endcase
   end

   assign take_dirty = rd_dirty_ff | (wr_ff & cmd.or_wr);

   always_ff @(posedge clock) begin
      if (cmd.load_cur) begin
         cur_ff <= cur_in;
         if (cmd.cur_src == tllru_pkg::CUR_HIT) begin
            cur_dirty_ff <= hit_dirty_ff;
         end
      end
      if (cmd.remove) begin
         cur_dirty_ff <= take_dirty;
         if (cmd.or_wr) begin
            hit_dirty_ff <= take_dirty;
         end
      end
   end

   // Unlink and push-to-head write decode.
   assign is_head    = head_ff[cmd.lst] == cur_ff;
   assign is_tail    = tail_ff[cmd.lst] == cur_ff;
   assign list_empty = count_ff[cmd.lst] == '0;
   assign push_dirty = cmd.insert ? wr_ff : cur_dirty_ff;

   always_comb begin
      newer_we = 1'b0;
      newer_wa = rd_older_ff;
      newer_wd = rd_newer_ff;
      older_we = 1'b0;
      older_wa = rd_newer_ff;
      older_wd = rd_older_ff;
      if (cmd.remove) begin
         older_we = !is_head;
         newer_we = !is_tail;
      end else if (cmd.push && !list_empty) begin
         newer_we = 1'b1;
         newer_wa = head_ff[cmd.lst];
         newer_wd = cur_ff;
         older_we = 1'b1;
         older_wa = cur_ff;
         older_wd = head_ff[cmd.lst];
      end
   end

   // List ends, which are read only while their list holds pages.
   always_ff @(posedge clock) begin
      if (cmd.remove) begin
         if (is_head) begin
            head_ff[cmd.lst] <= rd_older_ff;
         end
         if (is_tail) begin
            tail_ff[cmd.lst] <= rd_newer_ff;
         end
      end else if (cmd.push) begin
         head_ff[cmd.lst] <= cur_ff;
         if (list_empty) begin
            tail_ff[cmd.lst] <= cur_ff;
         end
      end
   end

   // List counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0] <= '0;
         count_ff[1] <= '0;
      end else if (cmd.remove) begin
         if (!list_empty) begin
            count_ff[cmd.lst] <= count_ff[cmd.lst] - CNT_W'(1);
         end
      end else if (cmd.push) begin
         count_ff[cmd.lst] <= count_ff[cmd.lst] + CNT_W'(1);
      end
   end

   // Per-slot valid bits, active marks and compare tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.push && cmd.insert) begin
         valid_ff[cur_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         active_ff[cur_ff] <= (cmd.lst == tllru_pkg::LIST_ACTIVE);
         if (cmd.insert) begin
            tag_cam_ff[cur_ff] <= page_ff;
         end
      end
   end

   // Tag memory, read for the evicted page.
   always_ff @(posedge clock) begin
      if (cmd.push && cmd.insert) begin
         tag_mem[cur_ff] <= page_ff;
      end
      if (cmd.read) begin
         rd_tag_ff <= tag_mem[cur_ff];
      end
   end

   // Dirty mark memory.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         dirty_mem[cur_ff] <= push_dirty;
      end
      if (cmd.read) begin
         rd_dirty_ff <= dirty_mem[cur_ff];
      end
   end

   // Link memories toward the head and toward the tail.
   always_ff @(posedge clock) begin
      if (newer_we) begin
         newer_mem[newer_wa] <= newer_wd;
      end
      if (cmd.read) begin
         rd_newer_ff <= newer_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[older_wa] <= older_wd;
      end
      if (cmd.read) begin
         rd_older_ff <= older_mem[cur_ff];
      end
   end

   // Eviction capture and result register.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         ev_ff       <= 1'b0;
         ev_page_ff  <= '0;
         ev_dirty_ff <= 1'b0;
      end else if (cmd.capture_ev) begin
         ev_ff       <= 1'b1;
         ev_page_ff  <= rd_tag_ff;
         ev_dirty_ff <= rd_dirty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit_kind      <= !hit_found_ff ? tllru_pkg::KIND_MISS :
                              (hit_active_ff ? tllru_pkg::KIND_ACTIVE :
                                               tllru_pkg::KIND_INACTIVE);
         rsp_evicted       <= ev_ff;
         rsp_evicted_page  <= ev_page_ff;
         rsp_evicted_dirty <= ev_dirty_ff;
      end
   end

`ifndef SYNTHESIS
   // Resident pages never exceed the slot count.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total <= TOT_W'(SLOTS))
      else $error("list counts exceed slot count");

   // A page is resident in at most one slot.
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_ff))
      else $error("page matched in more than one slot");

   // Every page on a list occupies a valid slot.
   a_valid_cover: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) >= int'(total))
      else $error("list counts exceed valid slots");
`endif

endmodule

`default_nettype wire

// ===== rtl/tllru_ctrl.sv =====
// Controller of the two-list LRU page cache: sequences lookup and list updates.
// Depends on tllru_pkg; drives tllru_dpath through command and status structs.
`default_nettype none

module tllru_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output tllru_pkg::cmd_type        cmd,
   input  wire  tllru_pkg::stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH,
      ST_ENC,
      ST_PLAN,
      ST_READ,
      ST_REM,
      ST_CHK,
      ST_PUSH,
      ST_RELOAD,
      ST_INS,
      ST_FIN
   } state_type;

   // Which update the current access is carrying out.
   typedef enum logic [1:0] {
      P_AHIT,
      P_IHIT,
      P_DEMOTE,
      P_EVICT
   } path_type;

   state_type state_ff;
   state_type state_in;
   path_type  path_ff;
   path_type  path_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Command decode and next state.
   always_comb begin
      cmd          = '0;
      cmd.cur_src  = tllru_pkg::CUR_HIT;
      cmd.lst      = tllru_pkg::LIST_ACTIVE;
      state_in     = state_ff;
      path_in      = path_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_ENC;
         end
         ST_ENC: begin
            cmd.encode = 1'b1;
            state_in   = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.load_cur = 1'b1;
            if (stat.hit_found) begin
               cmd.cur_src = tllru_pkg::CUR_HIT;
               path_in     = stat.hit_active ? P_AHIT : P_IHIT;
               state_in    = ST_READ;
            end else if (stat.evict_needed) begin
               cmd.cur_src = tllru_pkg::CUR_VICTIM;
               path_in     = P_EVICT;
               state_in    = ST_READ;
            end else begin
               cmd.cur_src = tllru_pkg::CUR_FREE;
               state_in    = ST_INS;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.remove = 1'b1;
            case (path_ff)
               P_AHIT: begin
                  cmd.lst   = tllru_pkg::LIST_ACTIVE;
                  cmd.or_wr = 1'b1;
                  state_in  = ST_PUSH;
               end
               P_IHIT: begin
                  cmd.lst   = tllru_pkg::LIST_INACTIVE;
                  cmd.or_wr = 1'b1;
                  state_in  = ST_CHK;
               end
               P_DEMOTE: begin
                  cmd.lst  = tllru_pkg::LIST_ACTIVE;
                  state_in = ST_PUSH;
               end
               default: begin
                  cmd.lst        = stat.victim_lst;
                  cmd.capture_ev = 1'b1;
                  state_in       = ST_INS;
               end
            endcase
         end
         ST_CHK: begin
            // Demote the active tail first when the active list is longer.
            if (stat.demote_needed) begin
               cmd.load_cur = 1'b1;
               cmd.cur_src  = tllru_pkg::CUR_ATAIL;
               path_in      = P_DEMOTE;
               state_in     = ST_READ;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (path_ff == P_DEMOTE) begin
               cmd.lst  = tllru_pkg::LIST_INACTIVE;
               state_in = ST_RELOAD;
            end else begin
               cmd.lst  = tllru_pkg::LIST_ACTIVE;
               state_in = ST_FIN;
            end
         end
         ST_RELOAD: begin
            cmd.load_cur = 1'b1;
            cmd.cur_src  = tllru_pkg::CUR_HIT;
            path_in      = P_IHIT;
            state_in     = ST_PUSH;
         end
         ST_INS: begin
            cmd.push   = 1'b1;
            cmd.insert = 1'b1;
            cmd.lst    = tllru_pkg::LIST_INACTIVE;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, path and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         path_ff      <= P_AHIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         path_ff      <= path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/two_list_lru_page_cache_top.sv =====
// Top level of the two-list LRU page cache: controller plus datapath.
// Depends on tllru_pkg, tllru_ctrl and tllru_dpath.
//
//   Channel  Ports                                     Flow control
//   req      req_page_number, req_is_write            req_valid / req_stall
//   rsp      rsp_hit_kind, rsp_evicted(_page,_dirty)  rsp_valid / rsp_stall
//   csr      csr_data (page_limit)                    csr_valid / csr_ready
//
// One request is in work at a time; a miss, an eviction, an active hit and an
// inactive hit, with or without a demotion, each take their own sequence of
// linked-list updates through the single-port link memories.
// The result register holds a finished result while the next request is accepted.
// A result that is still stalled when the next one finishes holds the controller,
// so the request after it is stalled until the result leaves.
// Reset is synchronous and empties both lists; page_limit returns to 255.
// The configuration port is always ready.
`default_nettype none

module two_list_lru_page_cache_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [tllru_pkg::PAGE_W-1:0]       req_page_number,
   input  wire                                req_is_write,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [tllru_pkg::KIND_W-1:0]       rsp_hit_kind,
   output logic                               rsp_evicted,
   output logic [tllru_pkg::PAGE_W-1:0]       rsp_evicted_page,
   output logic                               rsp_evicted_dirty,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [tllru_pkg::LIMIT_W-1:0]      csr_data
);

   tllru_pkg::cmd_type  cmd;
   tllru_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   // Sequencer.
   tllru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Lookup, lists and result register.
   tllru_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_page_number   (req_page_number),
      .req_is_write      (req_is_write),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_hit_kind      (rsp_hit_kind),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_evicted_dirty (rsp_evicted_dirty)
   );

endmodule

`default_nettype wire
